// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, switched off while reset is held.
`define AST_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define AST_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/fpmd_pkg.sv =====
package fpmd_pkg;

    localparam int DATA_W      = 32;
    localparam int MAG_W       = DATA_W + 1;
    localparam int GUARD_SHIFT = 14;

    typedef enum logic {
        KIND_MUL = 1'b0,
        KIND_DIV = 1'b1
    } t_kind;

    // One item as it moves through the guard and quotient stages. For a
    // multiply, q already holds the finished product and the rest is idle.
    typedef struct packed {
        t_kind              kind;
        logic               sat;
        logic               neg;
        logic [MAG_W-1:0]   ma;
        logic [MAG_W-1:0]   mb;
        logic [MAG_W-1:0]   rem;
        logic [DATA_W-1:0]  q;
    } t_stage;

    localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

// ===== hw/rtl/fpmd_div_step.sv =====
// One restoring-division stage: brings in one dividend bit and settles one
// quotient bit. Multiplies and saturated divides pass through unchanged.
module fpmd_div_step #(
    parameter int FRAC_BITS = 16,
    parameter int BIT_POS   = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  logic            i_vld,
    input  fpmd_pkg::t_stage i_st,
    output logic            o_vld,
    output fpmd_pkg::t_stage o_st
);

    localparam bit TAKES_A = (BIT_POS >= FRAC_BITS);
    localparam int A_IDX   = TAKES_A ? (BIT_POS - FRAC_BITS) : 0;

    logic                           r_vld;
    fpmd_pkg::t_stage               r_st;
    fpmd_pkg::t_stage               n_st;
    logic                           w_nbit;
    logic [fpmd_pkg::MAG_W:0]       w_trial;
    logic [fpmd_pkg::MAG_W:0]       w_diff;
    logic                           w_ge;

    assign w_nbit  = TAKES_A ? i_st.ma[A_IDX] : 1'b0;
    assign w_trial = {i_st.rem, w_nbit};
    assign w_diff  = w_trial - {1'b0, i_st.mb};
    assign w_ge    = (w_trial >= {1'b0, i_st.mb});

    always_comb begin
        n_st = i_st;
        if (i_st.kind == fpmd_pkg::KIND_DIV && !i_st.sat) begin
            n_st.rem = w_ge ? w_diff[fpmd_pkg::MAG_W-1:0] : w_trial[fpmd_pkg::MAG_W-1:0];
            n_st.q   = {i_st.q[fpmd_pkg::DATA_W-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_st <= n_st;
        end
    end

    assign o_vld = r_vld;
    assign o_st  = r_st;

endmodule

// ===== hw/rtl/fixed_point_mul_div_unit.sv =====
// Channel   Dir   Beat fields (lowest bit first)
// s_axis    in    tuser: kind; tdata: operand_a, operand_b
// m_axis    out   tuser: saturated; tdata: result
//
// A new beat can enter every cycle while no sink stall holds the pipeline; each
// beat passes stage 1, the guard stage, the one-bit quotient stages and the output register.
// Reset is synchronous and active low; it clears only the valid bits.
// Every stage holds its beat while the stage after it is full and stalled,
// and an empty stage always takes a new beat, so bubbles close up.
module fixed_point_mul_div_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // operand_a [31:0], operand_b [63:32]
    input  logic [0:0]  s_axis_tuser,   // kind [0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // result [31:0]
    output logic [0:0]  m_axis_tuser    // saturated [0]
);

    localparam int DW = fpmd_pkg::DATA_W;
    localparam int MW = fpmd_pkg::MAG_W;
    // Number of quotient bits a non-saturating divide can produce.
    localparam int QW = fpmd_pkg::GUARD_SHIFT + FRAC_BITS;

    // ------------------------------------------------------------------
    // Stage 1: operand magnitudes and the two multiplier partial products.
    // The multiply is split on operand_b into a signed high half and an
    // unsigned low half so no single multiplier exceeds 32 x 17 bits.
    // ------------------------------------------------------------------
    logic signed [DW-1:0]   w_a;
    logic signed [DW-1:0]   w_b;
    logic                   r_s1_vld;
    fpmd_pkg::t_kind        r_s1_kind;
    logic                   r_s1_neg;
    logic [MW-1:0]          r_s1_ma;
    logic [MW-1:0]          r_s1_mb;
    logic signed [48:0]     r_s1_pp_lo;
    logic signed [47:0]     r_s1_pp_hi;
    logic [MW-1:0]          n_s1_ma;
    logic [MW-1:0]          n_s1_mb;
    logic signed [48:0]     n_s1_pp_lo;
    logic signed [47:0]     n_s1_pp_hi;
    logic                   w_s1_ld;

    assign w_a = s_axis_tdata[DW-1:0];
    assign w_b = s_axis_tdata[2*DW-1:DW];

    // Magnitudes are exact at 33 bits, so the most negative value gives 2^31.
    assign n_s1_ma    = w_a[DW-1] ? (~{w_a[DW-1], w_a} + MW'(1)) : {1'b0, w_a};
    assign n_s1_mb    = w_b[DW-1] ? (~{w_b[DW-1], w_b} + MW'(1)) : {1'b0, w_b};
    assign n_s1_pp_lo = 49'(w_a) * 49'($signed({1'b0, w_b[15:0]}));
    assign n_s1_pp_hi = 48'(w_a) * 48'($signed(w_b[DW-1:16]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_s1_ld) begin
            r_s1_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_ld) begin
            r_s1_kind  <= fpmd_pkg::t_kind'(s_axis_tuser[0]);
            r_s1_neg   <= w_a[DW-1] ^ w_b[DW-1];
            r_s1_ma    <= n_s1_ma;
            r_s1_mb    <= n_s1_mb;
            r_s1_pp_lo <= n_s1_pp_lo;
            r_s1_pp_hi <= n_s1_pp_hi;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: overflow guard for divides, full product for multiplies.
    // The guard fires when (|a| >> 14) >= |b|, which covers b equal to
    // zero. Otherwise the quotient fits in QW bits and the remainder of
    // the first QW-aligned chunk of the dividend is simply |a| >> 14.
    // ------------------------------------------------------------------
    logic [63:0]            w_prod;
    logic [MW-1:0]          w_ma_hi;
    logic                   r_g_vld;
    fpmd_pkg::t_stage       r_g_st;
    fpmd_pkg::t_stage       n_g_st;

    assign w_prod  = {r_s1_pp_hi, 16'h0000} + {{15{r_s1_pp_lo[48]}}, r_s1_pp_lo};
    assign w_ma_hi = r_s1_ma >> fpmd_pkg::GUARD_SHIFT;

    always_comb begin
        n_g_st.kind = r_s1_kind;
        n_g_st.neg  = r_s1_neg;
        n_g_st.ma   = r_s1_ma;
        n_g_st.mb   = r_s1_mb;
        n_g_st.rem  = w_ma_hi;
        n_g_st.sat  = (w_ma_hi >= r_s1_mb);
        // An arithmetic shift leaves the kept low bits unaffected by the fill.
        n_g_st.q    = (r_s1_kind == fpmd_pkg::KIND_MUL) ? w_prod[FRAC_BITS +: DW] : '0;
    end

    // ------------------------------------------------------------------
    // Quotient chain: one stage per quotient bit, most significant first.
    // Entry 0 is the guard stage above, entry k the k-th division stage.
    // ------------------------------------------------------------------
    logic                   w_vld [0:QW];
    fpmd_pkg::t_stage       w_st  [0:QW];
    logic                   w_rdy [0:QW];
    logic                   w_out_ld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else if (w_rdy[0]) begin
            r_g_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_g_st <= n_g_st;
        end
    end

    assign w_vld[0] = r_g_vld;
    assign w_st[0]  = r_g_st;

    genvar k;
    generate
        for (k = 1; k <= QW; k++) begin : g_div
            fpmd_div_step #(
                .FRAC_BITS (FRAC_BITS),
                .BIT_POS   (QW - k)
            ) u_step (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_load  (w_rdy[k]),
                .i_vld   (w_vld[k-1]),
                .i_st    (w_st[k-1]),
                .o_vld   (w_vld[k]),
                .o_st    (w_st[k])
            );
        end

        // A stage may load when it is empty or its contents move on.
        for (k = 0; k < QW; k++) begin : g_rdy
            assign w_rdy[k] = !w_vld[k] || w_rdy[k+1];
        end
    endgenerate

    assign w_rdy[QW]     = !w_vld[QW] || w_out_ld;
    assign w_s1_ld       = !r_s1_vld || w_rdy[0];
    assign s_axis_tready = w_s1_ld;

    // ------------------------------------------------------------------
    // Output register: product pass-through, sign fix-up of the quotient and saturation select.
    // ------------------------------------------------------------------
    logic                   r_out_vld;
    logic [DW-1:0]          r_out_res;
    logic                   r_out_sat;
    logic [DW-1:0]          n_out_res;
    logic                   n_out_sat;
    fpmd_pkg::t_stage       w_last;

    assign w_last   = w_st[QW];
    assign w_out_ld = !r_out_vld || m_axis_tready;

    always_comb begin
        n_out_sat = 1'b0;
        if (w_last.kind == fpmd_pkg::KIND_MUL) begin
            n_out_res = w_last.q;
        end else if (w_last.sat) begin
            n_out_sat = 1'b1;
            n_out_res = w_last.neg ? fpmd_pkg::SAT_NEG : fpmd_pkg::SAT_POS;
        end else begin
            n_out_res = w_last.neg ? (~w_last.q + DW'(1)) : w_last.q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_ld) begin
            r_out_vld <= w_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ld) begin
            r_out_res <= n_out_res;
            r_out_sat <= n_out_sat;
        end
    end

    assign m_axis_tvalid   = r_out_vld;
    assign m_axis_tdata    = r_out_res;
    assign m_axis_tuser[0] = r_out_sat;

endmodule

// ===== hw/rtl/fpmd_checker.sv =====
`include "assert_macros.svh"

module fpmd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic [0:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic [0:0]  m_axis_tuser
);

    // Reset empties the whole pipeline.
    `AST_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

    // A stalled result beat keeps its payload.
    `AST_RST(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled output changed")

    // With the sink ready every stage can move, so the input side is ready.
    `AST_RST(a_flow, i_clk, i_rst_n, m_axis_tready |-> s_axis_tready, "input blocked while sink ready")

    // A saturated divide only ever returns one of the two extreme values.
    `AST_RST(a_sat_val, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 32'h7FFF_FFFF || m_axis_tdata == 32'h8000_0000, "bad saturated value")

endmodule

bind fixed_point_mul_div_unit fpmd_checker u_fpmd_checker (.*);

// ===== bench/fixed_point_mul_div_unit_tb.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the Q16.16 multiply/divide unit. Stimulus tasks push
// beats into the slave stream; a monitor predicts the result of each accepted beat
// and stores it in order. Every master-stream beat is compared with the oldest
// prediction. Both streams idle in random bursts, except in the last phase.
module fixed_point_mul_div_unit_tb;

    localparam int DATA_W      = fpmd_pkg::DATA_W;
    localparam int MAG_W       = fpmd_pkg::MAG_W;
    localparam int GUARD_SHIFT = fpmd_pkg::GUARD_SHIFT;
    localparam int FRAC_BITS   = 16;
    localparam int LATENCY     = GUARD_SHIFT + FRAC_BITS + 3;
    localparam int IDLE_LIMIT  = 2000;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              saturated;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;    // operand_a [31:0], operand_b [63:32]
    logic [0:0]  s_axis_tuser = '0;    // kind [0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // result [31:0]
    logic [0:0]  m_axis_tuser;         // saturated [0]

    t_outcome pending_outcomes[$];
    int       error_count = 0;
    bit       gaps_on = 1'b1;          // sender inserts idle bursts
    bit       stalls_on = 1'b1;        // receiver inserts stall bursts
    int       ready_hold = 0;

    fixed_point_mul_div_unit #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Exact magnitude of a two's complement word; the most negative value
    // comes out as 2^31, which is why one extra bit is kept.
    function automatic logic [MAG_W-1:0] magnitude33(logic [DATA_W-1:0] v);
        logic [MAG_W-1:0] wide;
        wide = {v[DATA_W-1], v};
        return v[DATA_W-1] ? (~wide + MAG_W'(1)) : wide;
    endfunction

    // Predicts one result beat: a wrapping shifted product, or a truncating
    // quotient behind the overflow guard that saturates by the operand signs.
    function automatic t_outcome fx_mul_div(fpmd_pkg::t_kind kind, logic [DATA_W-1:0] a,
                                            logic [DATA_W-1:0] b);
        t_outcome          o;
        logic signed [63:0] product;
        logic [MAG_W-1:0]  ma;
        logic [MAG_W-1:0]  mb;
        logic [63:0]       quotient;
        logic              neg;
        o.saturated = 1'b0;
        if (kind == fpmd_pkg::KIND_MUL) begin
            product  = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
            product  = product >>> FRAC_BITS;
            o.result = product[DATA_W-1:0];
        end else begin
            ma  = magnitude33(a);
            mb  = magnitude33(b);
            neg = a[DATA_W-1] ^ b[DATA_W-1];
            if ((ma >> GUARD_SHIFT) >= mb) begin
                // Covers division by zero too, since the shifted magnitude is
                // never below zero.
                o.saturated = 1'b1;
                o.result    = neg ? fpmd_pkg::SAT_NEG : fpmd_pkg::SAT_POS;
            end else begin
                quotient = ({31'b0, ma} << FRAC_BITS) / {31'b0, mb};
                if (neg) begin
                    quotient = ~quotient + 64'(1);
                end
                o.result = quotient[DATA_W-1:0];
            end
        end
        return o;
    endfunction

    // Receiver side: ready is held high or low in random bursts.
    always @(posedge i_clk) begin
        if (!stalls_on) begin
            m_axis_tready <= 1'b1;
            ready_hold    <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 2) != 0);
            ready_hold    <= $urandom_range(0, 6);
        end
    end

    // Scoreboard. The output beat is checked before the input beat of the same
    // edge is predicted, so a premature result can never match a new entry.
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_outcomes.size() == 0) begin
                    $display("%0t: unexpected result beat: expected none, got %h sat %b",
                             $time, m_axis_tdata, m_axis_tuser[0]);
                    error_count++;
                end else begin
                    want = pending_outcomes.pop_front();
                    if (m_axis_tdata !== want.result) begin
                        $display("%0t: result mismatch: expected %h, got %h",
                                 $time, want.result, m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tuser[0] !== want.saturated) begin
                        $display("%0t: saturated mismatch: expected %b, got %b",
                                 $time, want.saturated, m_axis_tuser[0]);
                        error_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pending_outcomes.push_back(fx_mul_div(fpmd_pkg::t_kind'(s_axis_tuser[0]),
                                                      s_axis_tdata[31:0],
                                                      s_axis_tdata[63:32]));
            end
        end
    end

    // Watchdog: ends the run when work is outstanding but no beat moves on
    // either stream for too long.
    initial begin
        int stuck_cycles;
        stuck_cycles = 0;
        while (stuck_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid || pending_outcomes.size() != 0) &&
                !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready)) begin
                stuck_cycles++;
            end else begin
                stuck_cycles = 0;
            end
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Sends one beat, optionally after a short idle burst, and returns at the
    // edge where it is accepted.
    task automatic send_op(fpmd_pkg::t_kind kind, logic [DATA_W-1:0] a,
                           logic [DATA_W-1:0] b);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Stops sending and waits until every predicted result has been seen.
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    // Operand mix: extremes, unit values, small magnitudes, full random words.
    function automatic logic [DATA_W-1:0] pick_operand();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = fpmd_pkg::SAT_NEG;
            1: v = fpmd_pkg::SAT_POS;
            2: v = $urandom_range(0, 4) == 0 ? 32'h0 : 32'hFFFF_FFFF;
            3: v = $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
            4, 5: v = 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
            default: v = $urandom();
        endcase
        return v;
    endfunction

    task automatic test_multiply_corners();
        send_op(fpmd_pkg::KIND_MUL, 32'h0000_0000, 32'h0000_0000);
        send_op(fpmd_pkg::KIND_MUL, 32'h0001_0000, 32'h0001_0000);   // 1.0 * 1.0
        send_op(fpmd_pkg::KIND_MUL, 32'h0001_8000, 32'hFFFE_0000);   // 1.5 * -2.0
        send_op(fpmd_pkg::KIND_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // smallest steps
        send_op(fpmd_pkg::KIND_MUL, 32'h0000_0001, 32'hFFFF_FFFF);   // shift of -1
        send_op(fpmd_pkg::KIND_MUL, fpmd_pkg::SAT_POS, fpmd_pkg::SAT_POS);   // wraps
        send_op(fpmd_pkg::KIND_MUL, fpmd_pkg::SAT_NEG, fpmd_pkg::SAT_NEG);
        send_op(fpmd_pkg::KIND_MUL, fpmd_pkg::SAT_NEG, fpmd_pkg::SAT_POS);
        send_op(fpmd_pkg::KIND_MUL, fpmd_pkg::SAT_NEG, 32'hFFFF_0000);   // -32768 * -1.0
        send_op(fpmd_pkg::KIND_MUL, 32'h1234_5678, 32'h9ABC_DEF0);
    endtask

    task automatic test_divide_corners();
        send_op(fpmd_pkg::KIND_DIV, 32'h0000_0000, 32'h0000_0000);   // zero by zero
        send_op(fpmd_pkg::KIND_DIV, 32'h0001_0000, 32'h0000_0000);   // by zero, positive
        send_op(fpmd_pkg::KIND_DIV, 32'hFFFF_0000, 32'h0000_0000);   // by zero, negative
        send_op(fpmd_pkg::KIND_DIV, fpmd_pkg::SAT_NEG, 32'h0000_0000);
        send_op(fpmd_pkg::KIND_DIV, 32'h0001_0000, 32'h0003_0000);   // 1 / 3 truncates
        send_op(fpmd_pkg::KIND_DIV, 32'hFFFF_0000, 32'h0003_0000);   // -1 / 3 toward zero
        send_op(fpmd_pkg::KIND_DIV, 32'h0007_0000, 32'hFFFE_0000);   // 7 / -2
        send_op(fpmd_pkg::KIND_DIV, fpmd_pkg::SAT_NEG, 32'hFFFF_FFFF);   // by tiny negative
        send_op(fpmd_pkg::KIND_DIV, fpmd_pkg::SAT_NEG, fpmd_pkg::SAT_NEG);   // both 2^31
        send_op(fpmd_pkg::KIND_DIV, fpmd_pkg::SAT_POS, fpmd_pkg::SAT_NEG);
        send_op(fpmd_pkg::KIND_DIV, fpmd_pkg::SAT_NEG, 32'h0002_0000);   // at the boundary
        send_op(fpmd_pkg::KIND_DIV, fpmd_pkg::SAT_NEG, 32'h0002_0001);   // one above it
        send_op(fpmd_pkg::KIND_DIV, fpmd_pkg::SAT_POS, 32'hFFFE_0000);   // negative divisor
        send_op(fpmd_pkg::KIND_DIV, 32'h0000_0000, 32'h0005_0000);
    endtask

    // Mostly random operations; halfway through the sender holds off until the
    // pipeline has emptied, then resumes.
    task automatic test_mixed_random(int count);
        for (int n = 0; n < count; n++) begin
            send_op(fpmd_pkg::t_kind'($urandom_range(0, 1)), pick_operand(), pick_operand());
            if (n == count / 2) begin
                wait_results_drained();
            end
        end
    endtask

    // Divides with the divisor magnitude one below, at, or one above the
    // shifted dividend magnitude, so the guard decision is exercised both ways.
    task automatic test_divide_guard_edge(int count);
        logic [DATA_W-1:0] a;
        logic [MAG_W-1:0]  mb;
        logic [DATA_W-1:0] b;
        for (int n = 0; n < count; n++) begin
            a  = pick_operand();
            mb = (magnitude33(a) >> GUARD_SHIFT) + MAG_W'($urandom_range(0, 2));
            if (mb != 0) begin
                mb = mb - MAG_W'(1);
            end
            b = mb[DATA_W-1:0];
            if ($urandom_range(0, 1)) begin
                b = ~b + DATA_W'(1);
            end
            send_op(fpmd_pkg::KIND_DIV, a, b);
        end
    endtask

    // Final phase: full rate on both sides with no idle cycles at all.
    task automatic test_back_to_back(int count);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        for (int n = 0; n < count; n++) begin
            send_op(fpmd_pkg::t_kind'($urandom_range(0, 1)), pick_operand(), pick_operand());
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_multiply_corners();
        test_divide_corners();
        test_mixed_random(700);
        test_divide_guard_edge(250);
        test_back_to_back(320);

        wait_results_drained();
        // Let any stray beat surface before the verdict.
        repeat (LATENCY + 20) @(posedge i_clk);
        if (pending_outcomes.size() != 0) begin
            $display("%0t: %0d results never arrived: expected 0 left, got %0d",
                     $time, pending_outcomes.size(), pending_outcomes.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
